[src/quad_four_triangle_interpolator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the four-triangle interpolator
// Concurrent checks sampled on clk_i; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef QUAD_FOUR_TRIANGLE_INTERPOLATOR_ASSERT_SVH
`define QUAD_FOUR_TRIANGLE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check that is suspended while reset is asserted.
`define QFTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that also holds while reset is asserted.
`define QFTI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QFTI_ASSERT(lbl, prop, msg)
`define QFTI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[src/qfti_pkg.sv]
// ----------------------------------------------------------------------------
// qfti_pkg
// Shared types for the four-triangle interpolator pipeline.
// ----------------------------------------------------------------------------
package qfti_pkg;

  // Triangle of the unit square that holds the point.
  typedef enum logic [1:0] {
    TRI_UPPER,
    TRI_RIGHT,
    TRI_BOTTOM,
    TRI_LEFT
  } tri_e;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic oor;
  } stage_ctl_t;

endpackage

[src/qfti_select.sv]
// ----------------------------------------------------------------------------
// qfti_select
// Picks the triangle, forms the rotated coordinates, the centre sum and the
// corner differences, and registers them for the multiply stage.
// ----------------------------------------------------------------------------
module qfti_select #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qfti_pkg::stage_ctl_t         ctl_i,
  input  logic [COORD_FRAC_BITS:0]     x_i,
  input  logic [COORD_FRAC_BITS:0]     y_i,
  input  logic signed [SAMPLE_BITS-1:0] v00_i,
  input  logic signed [SAMPLE_BITS-1:0] v01_i,
  input  logic signed [SAMPLE_BITS-1:0] v11_i,
  input  logic signed [SAMPLE_BITS-1:0] v10_i,
  output qfti_pkg::stage_ctl_t         ctl_o,
  output logic signed [SAMPLE_BITS+1:0] c4_o,
  output logic signed [SAMPLE_BITS+2:0] da_o,
  output logic signed [SAMPLE_BITS+2:0] db_o,
  output logic signed [COORD_FRAC_BITS+1:0] nx_o,
  output logic signed [COORD_FRAC_BITS+1:0] ny_o
);
  import qfti_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int S    = SAMPLE_BITS;
  localparam int ONE  = 2 ** F;
  localparam int HALF = 2 ** (F - 1);

  tri_e                 tri_sel;
  logic [F+1:0]         sum_xy;
  logic signed [F+1:0]  u, w;
  logic signed [S+1:0]  c4;
  logic signed [S-1:0]  va, vb;
  logic signed [S+2:0]  c4_ext;
  stage_ctl_t           ctl_q;
  logic signed [S+1:0]  c4_q;
  logic signed [S+2:0]  da_d, db_d, da_q, db_q;
  logic signed [F+1:0]  nx_d, ny_d, nx_q, ny_q;

  // Centre sum in quarter units and coordinates about the square's centre.
  assign c4     = (S+2)'(v00_i) + (S+2)'(v01_i) + (S+2)'(v11_i) + (S+2)'(v10_i);
  assign c4_ext = (S+3)'(c4);
  assign sum_xy = {1'b0, x_i} + {1'b0, y_i};
  assign u      = $signed({1'b0, x_i}) - $signed((F+2)'(HALF));
  assign w      = $signed({1'b0, y_i}) - $signed((F+2)'(HALF));

  // Diagonal tests; ties on y = x fall to the left triangle.
  always_comb begin
    priority if (sum_xy > (F+2)'(ONE) && y_i > x_i) begin
      tri_sel = TRI_UPPER;
    end else if (sum_xy > (F+2)'(ONE) && y_i < x_i) begin
      tri_sel = TRI_RIGHT;
    end else if (sum_xy <= (F+2)'(ONE) && y_i < x_i) begin
      tri_sel = TRI_BOTTOM;
    end else begin
      tri_sel = TRI_LEFT;
    end
  end

  // Rotated coordinates and the two corners of the chosen triangle.
  always_comb begin
    unique case (tri_sel)
      TRI_UPPER: begin
        nx_d = u + w;  ny_d = w - u;  va = v01_i; vb = v11_i;
      end
      TRI_RIGHT: begin
        nx_d = u - w;  ny_d = u + w;  va = v11_i; vb = v10_i;
      end
      TRI_BOTTOM: begin
        nx_d = -u - w; ny_d = u - w;  va = v10_i; vb = v00_i;
      end
      default: begin
        nx_d = w - u;  ny_d = -u - w; va = v00_i; vb = v01_i;
      end
    endcase
  end

  // Corner weights relative to the centre, in quarter units.
  assign da_d = $signed({va, 2'b00}) - c4_ext;
  assign db_d = $signed({vb, 2'b00}) - c4_ext;

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    c4_q <= c4;
    da_q <= da_d;
    db_q <= db_d;
    nx_q <= nx_d;
    ny_q <= ny_d;
  end

  assign ctl_o = ctl_q;
  assign c4_o  = c4_q;
  assign da_o  = da_q;
  assign db_o  = db_q;
  assign nx_o  = nx_q;
  assign ny_o  = ny_q;

endmodule

[src/qfti_mac.sv]
// ----------------------------------------------------------------------------
// qfti_mac
// Multiplies the corner weights by the rotated coordinates, then sums with
// the centre term, rounds half up and saturates into the result register.
// ----------------------------------------------------------------------------
module qfti_mac #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qfti_pkg::stage_ctl_t              ctl_i,
  input  logic signed [SAMPLE_BITS+1:0]     c4_i,
  input  logic signed [SAMPLE_BITS+2:0]     da_i,
  input  logic signed [SAMPLE_BITS+2:0]     db_i,
  input  logic signed [COORD_FRAC_BITS+1:0] nx_i,
  input  logic signed [COORD_FRAC_BITS+1:0] ny_i,
  output qfti_pkg::stage_ctl_t              ctl_o,
  output logic signed [SAMPLE_BITS-1:0]     result_o
);
  import qfti_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int S  = SAMPLE_BITS;
  localparam int PW = S + F + 5;
  localparam int TW = S + F + 7;
  localparam int RW = S + 5;
  localparam logic signed [TW-1:0] RND = TW'(2 ** (F + 1));

  stage_ctl_t           prod_ctl_q, res_ctl_q;
  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic signed [S+1:0]  c4_q;
  logic signed [TW-1:0] c_ext, t_sum;
  logic signed [RW-1:0] r_full;
  logic signed [S-1:0]  res_d, res_q;

  // Products of weights and rotated coordinates.
  assign pb_d = db_i * nx_i;
  assign pa_d = da_i * ny_i;

  // Exact sum scaled by four and one, with the rounding bias.
  assign c_ext = TW'(c4_q);
  assign t_sum = (c_ext <<< F) + TW'(pb_q) + TW'(pa_q) + RND;
  assign r_full = $signed(t_sum[TW-1:F+2]);

  // Saturate to the sample range; out-of-range points give zero.
  always_comb begin
    if (prod_ctl_q.oor) begin
      res_d = '0;
    end else if (r_full[RW-1:S-1] == '0 || r_full[RW-1:S-1] == '1) begin
      res_d = r_full[S-1:0];
    end else if (r_full[RW-1]) begin
      res_d = {1'b1, {(S-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(S-1){1'b1}}};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctl_q <= '0;
      res_ctl_q  <= '0;
    end else begin
      prod_ctl_q <= ctl_i;
      res_ctl_q  <= prod_ctl_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    c4_q  <= c4_i;
    res_q <= res_d;
  end

  assign ctl_o    = res_ctl_q;
  assign result_o = res_q;

endmodule

[src/quad_four_triangle_interpolator.sv]
// ----------------------------------------------------------------------------
// quad_four_triangle_interpolator
// Four-triangle piecewise linear interpolation of a point in the unit square.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+--------------------------------------------
//   input    | start, busy        | coord_x_i, coord_y_i, corner_00_i..10_i
//   result   | done_o (strobe)    | interpolated_o, out_of_range_o
//
// One word is taken every cycle; busy is never raised.
// Registers in order: input register, triangle select, multiply, and the
// round and saturate stage that feeds the result register.
// Reset clears the valid bits of every stage; no word is lost or repeated.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "quad_four_triangle_interpolator_assert.svh"

module quad_four_triangle_interpolator #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_FRAC_BITS:0]      coord_x_i,
  input  logic [COORD_FRAC_BITS:0]      coord_y_i,
  input  logic signed [SAMPLE_BITS-1:0] corner_00_i,
  input  logic signed [SAMPLE_BITS-1:0] corner_01_i,
  input  logic signed [SAMPLE_BITS-1:0] corner_11_i,
  input  logic signed [SAMPLE_BITS-1:0] corner_10_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] interpolated_o,
  output logic                          out_of_range_o
);
  import qfti_pkg::*;

  localparam int F = COORD_FRAC_BITS;
  localparam int S = SAMPLE_BITS;

  logic                 accept;
  logic                 coord_oor;
  stage_ctl_t           in_ctl_d, in_ctl_q, sel_ctl, res_ctl;
  logic [F:0]           x_q, y_q;
  logic signed [S-1:0]  v00_q, v01_q, v11_q, v10_q;
  logic signed [S+1:0]  c4;
  logic signed [S+2:0]  da, db;
  logic signed [F+1:0]  nx, ny;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // A coordinate is out of range when it is above exactly one.
  assign coord_oor = (coord_x_i[F] && (coord_x_i[F-1:0] != '0)) ||
                     (coord_y_i[F] && (coord_y_i[F-1:0] != '0));

  assign in_ctl_d.valid = accept;
  assign in_ctl_d.oor   = coord_oor;

  // Input control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q <= in_ctl_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= coord_x_i;
      y_q   <= coord_y_i;
      v00_q <= corner_00_i;
      v01_q <= corner_01_i;
      v11_q <= corner_11_i;
      v10_q <= corner_10_i;
    end
  end

  qfti_select #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_select (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (in_ctl_q),
    .x_i   (x_q),
    .y_i   (y_q),
    .v00_i (v00_q),
    .v01_i (v01_q),
    .v11_i (v11_q),
    .v10_i (v10_q),
    .ctl_o (sel_ctl),
    .c4_o  (c4),
    .da_o  (da),
    .db_o  (db),
    .nx_o  (nx),
    .ny_o  (ny)
  );

  qfti_mac #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sel_ctl),
    .c4_i    (c4),
    .da_i    (da),
    .db_i    (db),
    .nx_i    (nx),
    .ny_i    (ny),
    .ctl_o   (res_ctl),
    .result_o(interpolated_o)
  );

  assign done_o         = res_ctl.valid;
  assign out_of_range_o = res_ctl.oor;

  // Every accepted word comes out as a result, and nothing else does.
  `QFTI_ASSERT(a_latency, accept |-> ##4 done_o, "accepted word did not complete")
  `QFTI_ASSERT(a_no_phantom, done_o |-> $past(accept, 4), "result without a word")
  // The error flag follows the coordinates of the same word and zeroes the value.
  `QFTI_ASSERT(a_oor_track, done_o |-> (out_of_range_o == $past(coord_oor, 4)),
               "range flag does not match the word")
  `QFTI_ASSERT(a_oor_zero, (done_o && out_of_range_o) |-> (interpolated_o == '0),
               "out-of-range word gave a nonzero value")
  // Reset empties the pipeline.
  `QFTI_ASSERT_RST(a_reset_flush, !rst_ni |=> !done_o, "result strobe during reset")

endmodule

[tb/quad_four_triangle_interpolator_test.sv]
// ----------------------------------------------------------------------------
// quad_four_triangle_interpolator_test
// Drives points and corner samples into the four-triangle interpolator with
// random gaps, predicts every result word in the testbench, and compares each
// strobed result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module quad_four_triangle_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qfti_pkg::*;

  localparam int COORD_FRAC_BITS = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int COORD_BITS      = COORD_FRAC_BITS + 1;
  localparam int RANDOM_POINTS   = 800;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_REPORTS     = 10;
  localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1 << COORD_FRAC_BITS);
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // One input word: a point and the four corner samples.
  typedef struct packed {
    logic [COORD_BITS-1:0]         x;
    logic [COORD_BITS-1:0]         y;
    logic signed [SAMPLE_BITS-1:0] c00;
    logic signed [SAMPLE_BITS-1:0] c01;
    logic signed [SAMPLE_BITS-1:0] c11;
    logic signed [SAMPLE_BITS-1:0] c10;
  } point_t;

  // One result word.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          oor;
  } sample_out_t;

  // A directed row; when known is set the result is typed in.
  typedef struct packed {
    point_t      pt;
    logic        known;
    sample_out_t want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 24;

  // Directed points: corners, range edges, each triangle, the diagonals,
  // saturation at (1,1) and out-of-range coordinates.
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{17'd0, 17'd0, 16'sd100, 16'sd200, 16'sd300, 16'sd400}, 1'b1, '{16'sd100, 1'b0}},
    '{'{COORD_ONE, COORD_ONE, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX},
      1'b1, '{SAMPLE_MAX, 1'b0}},
    '{'{COORD_ONE, COORD_ONE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN},
      1'b1, '{SAMPLE_MIN, 1'b0}},
    '{'{17'd12345, 17'd54321, 16'sd1234, 16'sd1234, 16'sd1234, 16'sd1234},
      1'b1, '{16'sd1234, 1'b0}},
    '{'{COORD_ONE, 17'd0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN},
      1'b1, '{SAMPLE_MIN, 1'b0}},
    '{'{17'd0, COORD_ONE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX},
      1'b1, '{SAMPLE_MAX, 1'b0}},
    '{'{COORD_ONE + 17'd1, 17'd0, 16'sd5, 16'sd6, 16'sd7, 16'sd8}, 1'b1, '{16'sd0, 1'b1}},
    '{'{17'd0, COORD_ONE + 17'd1, SAMPLE_MAX, SAMPLE_MIN, 16'sd7, -16'sd8},
      1'b1, '{16'sd0, 1'b1}},
    '{'{COORD_MAX, COORD_MAX, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, '{16'sd0, 1'b1}},
    '{'{COORD_ONE, COORD_ONE + 17'd1, 16'sd9, 16'sd9, 16'sd9, 16'sd9}, 1'b1, '{16'sd0, 1'b1}},
    '{'{17'd20000, 17'd60000, SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1}, 1'b0, '0},
    '{'{17'd60000, 17'd20000, 16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000}, 1'b0, '0},
    '{'{17'd40000, 17'd10000, 16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000}, 1'b0, '0},
    '{'{17'd10000, 17'd40000, 16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000}, 1'b0, '0},
    '{'{17'd50000, 17'd50000, 16'sd17, -16'sd300, 16'sd2500, 16'sd99}, 1'b0, '0},
    '{'{17'd20000, 17'd20000, 16'sd17, -16'sd300, 16'sd2500, 16'sd99}, 1'b0, '0},
    '{'{17'd40000, 17'd25536, -16'sd7, 16'sd11, -16'sd13, 16'sd19}, 1'b0, '0},
    '{'{17'd25536, 17'd40000, -16'sd7, 16'sd11, -16'sd13, 16'sd19}, 1'b0, '0},
    '{'{17'd32768, 17'd32768, 16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b0, '0},
    '{'{17'd1, 17'd1, 16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b0, '0},
    '{'{COORD_ONE, 17'd0, 16'sd5, -16'sd6, 16'sd7, -16'sd8}, 1'b0, '0},
    '{'{17'd0, COORD_ONE, 16'sd5, -16'sd6, 16'sd7, -16'sd8}, 1'b0, '0},
    '{'{17'd65535, 17'd1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN}, 1'b0, '0},
    '{'{17'd1, 17'd65535, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX}, 1'b0, '0}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [COORD_BITS-1:0]         coord_x;
  logic [COORD_BITS-1:0]         coord_y;
  logic signed [SAMPLE_BITS-1:0] corner_00;
  logic signed [SAMPLE_BITS-1:0] corner_01;
  logic signed [SAMPLE_BITS-1:0] corner_11;
  logic signed [SAMPLE_BITS-1:0] corner_10;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] interpolated;
  logic                          out_of_range;

  sample_out_t pending_samples[$];
  sample_out_t oldest_sample;
  int unsigned fault_count;

  quad_four_triangle_interpolator #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .coord_x_i     (coord_x),
    .coord_y_i     (coord_y),
    .corner_00_i   (corner_00),
    .corner_01_i   (corner_01),
    .corner_11_i   (corner_11),
    .corner_10_i   (corner_10),
    .done_o        (done),
    .interpolated_o(interpolated),
    .out_of_range_o(out_of_range)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Evaluate the plane of the triangle holding the point, in quarter sample
  // units scaled by 2^F, then round half up and saturate.
  function automatic sample_out_t interpolate_point(point_t p);
    longint      one;
    longint      half;
    longint      x;
    longint      y;
    longint      v00;
    longint      v01;
    longint      v11;
    longint      v10;
    longint      c4;
    longint      u;
    longint      w;
    longint      nx;
    longint      ny;
    longint      va;
    longint      vb;
    longint      t;
    longint      r;
    tri_e        region;
    sample_out_t res;
    one  = longint'(1) <<< COORD_FRAC_BITS;
    half = longint'(1) <<< (COORD_FRAC_BITS - 1);
    x    = longint'(p.x);
    y    = longint'(p.y);
    v00  = longint'(p.c00);
    v01  = longint'(p.c01);
    v11  = longint'(p.c11);
    v10  = longint'(p.c10);
    if (x > one || y > one) begin
      res.value = '0;
      res.oor   = 1'b1;
      return res;
    end
    c4 = v00 + v01 + v11 + v10;
    u  = x - half;
    w  = y - half;
    // Points on y = x above the anti-diagonal fall into the left triangle.
    if (x + y > one && y > x) begin
      region = TRI_UPPER;
    end else if (x + y > one && y < x) begin
      region = TRI_RIGHT;
    end else if (y < x) begin
      region = TRI_BOTTOM;
    end else begin
      region = TRI_LEFT;
    end
    case (region)
      TRI_UPPER: begin
        nx = u + w;  ny = -u + w; va = v01; vb = v11;
      end
      TRI_RIGHT: begin
        nx = u - w;  ny = u + w;  va = v11; vb = v10;
      end
      TRI_BOTTOM: begin
        nx = -u - w; ny = u - w;  va = v10; vb = v00;
      end
      default: begin
        nx = -u + w; ny = -u - w; va = v00; vb = v01;
      end
    endcase
    t = c4 * one + (4 * vb - c4) * nx + (4 * va - c4) * ny;
    r = (t + (longint'(1) <<< (COORD_FRAC_BITS + 1))) >>> (COORD_FRAC_BITS + 2);
    if (r > longint'(SAMPLE_MAX)) r = longint'(SAMPLE_MAX);
    if (r < longint'(SAMPLE_MIN)) r = longint'(SAMPLE_MIN);
    res.value = r[SAMPLE_BITS-1:0];
    res.oor   = 1'b0;
    return res;
  endfunction

  // Coordinates lean toward the edges of the unit square; a few are drawn
  // over the whole field so that every bit toggles and some fall out of range.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COORD_ONE;
      2:       return COORD_BITS'($urandom_range(0, 2**COORD_BITS - 1));
      default: return COORD_BITS'($urandom_range(0, 2**COORD_FRAC_BITS));
    endcase
  endfunction

  // Samples are mostly uniform, with the extremes mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Wait the gap, present the word, hold it until it is taken and then log
  // the result that it should produce.
  task automatic send_point(input point_t p, input sample_out_t want,
                            input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    coord_x   <= p.x;
    coord_y   <= p.y;
    corner_00 <= p.c00;
    corner_01 <= p.c01;
    corner_11 <= p.c11;
    corner_10 <= p.c10;
    start     <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_samples.push_back(want);
  endtask

  // Result checker: every strobed word must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done !== 1'b0) begin
      if (pending_samples.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("unexpected result word: interpolated=%0d out_of_range=%b",
                   interpolated, out_of_range);
        end
      end else begin
        oldest_sample = pending_samples.pop_front();
        if (interpolated !== oldest_sample.value || out_of_range !== oldest_sample.oor) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("mismatch: expected %0d/%b, got %0d/%b", oldest_sample.value,
                     oldest_sample.oor, interpolated, out_of_range);
          end
        end
      end
    end
  end

  // Stimulus: directed table, then random points with random gaps.
  initial begin
    point_t      pt;
    sample_out_t want;
    int unsigned gap;
    bit          no_idle;
    fault_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    coord_x     = '0;
    coord_y     = '0;
    corner_00   = '0;
    corner_01   = '0;
    corner_11   = '0;
    corner_10   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      want = DIRECTED[i].known ? DIRECTED[i].want : interpolate_point(DIRECTED[i].pt);
      send_point(DIRECTED[i].pt, want, $urandom_range(0, 19));
    end

    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      // Alternate stretches of back-to-back words with stretches of gaps.
      if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pt.x   = pick_coord();
      pt.y   = pick_coord();
      // Put a share of the points on one of the two diagonals.
      case ($urandom_range(0, 7))
        0: pt.y = pt.x;
        1: if (pt.x <= COORD_ONE) pt.y = COORD_ONE - pt.x;
        default: ;
      endcase
      pt.c00 = pick_sample();
      pt.c01 = pick_sample();
      pt.c11 = pick_sample();
      pt.c10 = pick_sample();
      gap    = no_idle ? 0 : $urandom_range(0, 19);
      send_point(pt, interpolate_point(pt), gap);
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[quad_four_triangle_interpolator] OK");
    end else begin
      $display("[quad_four_triangle_interpolator] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing results.
  initial begin
    #2_000_000;
    $display("[quad_four_triangle_interpolator] ERROR");
    $finish;
  end

endmodule

[quad_four_triangle_interpolator.f]
+incdir+src
src/qfti_pkg.sv
src/qfti_select.sv
src/qfti_mac.sv
src/quad_four_triangle_interpolator.sv
tb/quad_four_triangle_interpolator_test.sv
